// ----- design/zpc_pkg.sv -----
// Package for the ZMP preview controller: codes, sequencer types and defaults.
`timescale 1ns / 1ps
`default_nettype none
package zpc_pkg;

    // Defaults for the top level parameters
    localparam int ZPC_PREVIEW_STEPS = 64;
    localparam int ZPC_DATA_WIDTH    = 32;

    // Port widths
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 192;
    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_DATA_W  = 32;

    // Q16.16 rounding
    localparam int Q_FRAC     = 16;
    localparam int ROUND_HALF = 32768;

    // Item kinds carried in tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_INTEGRAL_GAIN = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_POS_GAIN      = 4'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_VEL_GAIN      = 4'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_ACC_GAIN      = 4'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_HEIGHT_FACTOR = 4'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_DT       = 4'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_DT2_HALF = 4'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_DT3_SIXTH = 4'd7;

    // Reset values of the timing registers
    localparam logic [30:0] DT_RESET  = 31'd655;
    localparam logic [30:0] DT2_RESET = 31'd3;
    localparam logic [30:0] DT3_RESET = 31'd0;

    // Sequencer phase
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ISSUE,
        PH_DRAIN,
        PH_CLOSE,
        PH_OUT
    } phase_t;

    // Group of products summed into one value
    typedef enum logic [2:0] {
        GR_U,
        GR_N0,
        GR_N1,
        GR_N2,
        GR_Z,
        GR_E
    } group_t;

endpackage : zpc_pkg
`default_nettype wire

// ----- design/zmp_preview_control_step_top.sv -----
// Top level of the two-axis cart-table ZMP preview controller.
`timescale 1ns / 1ps
`default_nettype none
// Two-axis cart-table ZMP preview controller, Q16.16. A load item (tuser 0) writes one
// preview gain; a tick (tuser 1) stores its reference pair and, once the window holds
// PREVIEW_STEPS entries, runs the control step for x and then y on one shared
// multiply-accumulate pipeline fed by the gain and reference memories. Each axis
// streams PREVIEW_STEPS+4 products through the pipeline, then the short dependent
// state-update sums; every group waits for the four-stage pipeline to drain and then
// closes, and the output register is loaded last. The result sits in an output
// register; the block takes new items while it waits there, and holds a later tick's
// result until it is taken. Gains must be written by the user before they are read;
// the block does not enforce it. Window entries are read only after being written.
module zmp_preview_control_step_top
    import zpc_pkg::*;
#(
    parameter int PREVIEW_STEPS = ZPC_PREVIEW_STEPS,
    parameter int DATA_WIDTH    = ZPC_DATA_WIDTH
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_tvalid,
    output logic                   s_tready,
    // gain_index[5:0], gain_value[37:6], ref_x[69:38], ref_y[101:70], zero pad
    input  wire [IN_TDATA_W-1:0]   s_tdata,
    // cmd[0]
    input  wire [0:0]              s_tuser,
    output logic                   m_tvalid,
    input  wire                    m_tready,
    // com_x[31:0], com_vel_x[63:32], com_acc_x[95:64],
    // com_y[127:96], com_vel_y[159:128], com_acc_y[191:160]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  wire                    cfg_wr_en,
    input  wire [CFG_ADDR_W-1:0]   cfg_addr,
    input  wire [CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int DW    = DATA_WIDTH;
    localparam int BW    = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
    localparam int AW    = (PREVIEW_STEPS > 1) ? $clog2(PREVIEW_STEPS) : 1;
    localparam int CW    = $clog2(PREVIEW_STEPS + 1);
    localparam int KW    = $clog2(PREVIEW_STEPS + 5);
    localparam int ACC_W = BW + KW + 2;
    localparam int HALF  = (BW + 1) / 2;
    localparam int HI_W  = BW - HALF;
    localparam int PW    = 32 + BW;
    localparam int RW    = PW + 1 - Q_FRAC;

    localparam logic [KW-1:0] U_TERMS  = KW'(PREVIEW_STEPS + 4);
    localparam logic [KW-1:0] U_MEM_K  = KW'(4);
    localparam logic [AW-1:0] LAST_IDX = AW'(PREVIEW_STEPS - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(PREVIEW_STEPS - 1);
    localparam logic [RW-1:0] LIM_POS  = {{(RW - DW + 1){1'b0}}, {(DW - 1){1'b1}}};
    localparam logic [RW-1:0] LIM_NEG  = LIM_POS + RW'(1);
    localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W - DW + 1){1'b0}}, {(DW - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

    // Clamp an exact sum to DATA_WIDTH bits
    function automatic logic signed [DW-1:0] sat_dw(input logic signed [ACC_W-1:0] v);
        if (v > SAT_HI) begin
            return SAT_HI[DW-1:0];
        end else if (v < SAT_LO) begin
            return SAT_LO[DW-1:0];
        end
        return v[DW-1:0];
    endfunction

    // Low 32 bits of a state value, sign-extended first
    function automatic logic [31:0] out32(input logic signed [DW-1:0] v);
        logic signed [BW-1:0] w;
        w = BW'(v);
        return w[31:0];
    endfunction

    // Input fields
    logic               in_cmd;
    logic [5:0]         in_gidx;
    logic signed [31:0] in_gval;
    logic signed [31:0] in_refx;
    logic signed [31:0] in_refy;
    logic               s_acc;

    assign in_cmd  = s_tuser[0];
    assign in_gidx = s_tdata[5:0];
    assign in_gval = s_tdata[37:6];
    assign in_refx = s_tdata[69:38];
    assign in_refy = s_tdata[101:70];
    assign s_acc   = s_tvalid && s_tready;

    // Configuration registers
    logic signed [31:0] ki_reg, kp_reg, kv_reg, ka_reg;
    logic [30:0]        hf_reg, dt_reg, dt2_reg, dt3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ki_reg  <= '0;
            kp_reg  <= '0;
            kv_reg  <= '0;
            ka_reg  <= '0;
            hf_reg  <= '0;
            dt_reg  <= DT_RESET;
            dt2_reg <= DT2_RESET;
            dt3_reg <= DT3_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_INTEGRAL_GAIN:  ki_reg  <= cfg_wdata;
                CFG_POS_GAIN:       kp_reg  <= cfg_wdata;
                CFG_VEL_GAIN:       kv_reg  <= cfg_wdata;
                CFG_ACC_GAIN:       ka_reg  <= cfg_wdata;
                CFG_HEIGHT_FACTOR:  hf_reg  <= cfg_wdata[30:0];
                CFG_STEP_DT:        dt_reg  <= cfg_wdata[30:0];
                CFG_STEP_DT2_HALF:  dt2_reg <= cfg_wdata[30:0];
                CFG_STEP_DT3_SIXTH: dt3_reg <= cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    // Sequencer and window state
    phase_t          phase_reg, phase_next;
    group_t          group_reg, group_next;
    logic            axis_reg, axis_next;
    logic [KW-1:0]   kcnt_reg, kcnt_next;
    logic [AW-1:0]   gidx_reg, gidx_next;
    logic [AW-1:0]   rptr_reg, rptr_next;
    logic [AW-1:0]   head_reg, head_next;
    logic [CW-1:0]   count_reg, count_next;

    // Pipeline
    logic                   p1_v_reg, p1_v_next, p2_v_reg, p3_v_reg, p4_v_reg;
    logic                   p1_mem_reg, p1_mem_next, p1_first_reg, p1_first_next;
    logic signed [31:0]     p1_a_reg, p1_a_next;
    logic signed [DW-1:0]   p1_b_reg, p1_b_next;
    logic                   p2_neg_reg, p3_neg_reg;
    logic [31:0]            p2_ma_reg;
    logic [BW-1:0]          p2_mb_reg;
    logic [32+HALF-1:0]     p3_lo_reg;
    logic [32+HI_W-1:0]     p3_hi_reg;
    logic signed [DW-1:0]   p4_term_reg;

    // Arithmetic state
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [DW-1:0]    u_reg, u_next, n0_reg, n0_next, n1_reg, n1_next;
    logic signed [DW-1:0]    n2_reg, n2_next;
    logic signed [31:0]      ref0_reg, ref0_next;
    logic signed [DW-1:0]    sx0_reg, sx1_reg, sx2_reg, ex_reg;
    logic signed [DW-1:0]    sy0_reg, sy1_reg, sy2_reg, ey_reg;
    logic signed [DW-1:0]    sx0_next, sx1_next, sx2_next, ex_next;
    logic signed [DW-1:0]    sy0_next, sy1_next, sy2_next, ey_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0]  m_data_reg, m_data_next;

    // Memories
    logic signed [31:0] gain_mem [PREVIEW_STEPS];
    logic [63:0]        ref_mem  [PREVIEW_STEPS];
    logic signed [31:0] gain_q;
    logic [63:0]        ref_q;
    logic [AW:0]        wr_sum;
    logic [AW-1:0]      wr_ptr;

    // Write slot of each accepted tick
    always_comb begin
        wr_sum = (AW + 1)'(head_reg) + (AW + 1)'(count_reg);
        if (wr_sum >= (AW + 1)'(PREVIEW_STEPS)) begin
            wr_sum = wr_sum - (AW + 1)'(PREVIEW_STEPS);
        end
        wr_ptr = wr_sum[AW-1:0];
    end

    // Write gains and references on accept; read every cycle
    always_ff @(posedge aclk) begin
        if (s_acc && in_cmd == CMD_LOAD && 32'(in_gidx) < 32'(PREVIEW_STEPS)) begin
            gain_mem[AW'(in_gidx)] <= in_gval;
        end
        if (s_acc && in_cmd == CMD_TICK) begin
            ref_mem[wr_ptr] <= {in_refy, in_refx};
        end
        gain_q <= gain_mem[gidx_reg];
        ref_q  <= ref_mem[rptr_reg];
    end

    // Current axis view
    logic signed [DW-1:0] cs0, cs1, cs2, cerr;
    logic [KW-1:0]        nterms;
    logic                 pipe_empty;
    logic signed [DW-1:0] sat_v;

    assign cs0  = axis_reg ? sy0_reg : sx0_reg;
    assign cs1  = axis_reg ? sy1_reg : sx1_reg;
    assign cs2  = axis_reg ? sy2_reg : sx2_reg;
    assign cerr = axis_reg ? ey_reg : ex_reg;
    assign pipe_empty = !(p1_v_reg || p2_v_reg || p3_v_reg || p4_v_reg);
    assign sat_v = sat_dw(acc_reg);

    always_comb begin
        case (group_reg)
            GR_U:    nterms = U_TERMS;
            GR_N0:   nterms = KW'(3);
            GR_N1:   nterms = KW'(2);
            GR_N2:   nterms = KW'(1);
            GR_Z:    nterms = KW'(1);
            default: nterms = '0;
        endcase
    end

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE: begin
                if (s_acc && in_cmd == CMD_TICK && count_reg == FULL_CNT) begin
                    phase_next = PH_ISSUE;
                end
            end
            PH_ISSUE: begin
                if (kcnt_reg == nterms - KW'(1)) begin
                    phase_next = PH_DRAIN;
                end
            end
            PH_DRAIN: begin
                if (pipe_empty) begin
                    phase_next = PH_CLOSE;
                end
            end
            PH_CLOSE: begin
                if (group_reg == GR_E && axis_reg) begin
                    phase_next = PH_OUT;
                end else if (group_reg == GR_Z) begin
                    phase_next = PH_DRAIN;
                end else begin
                    phase_next = PH_ISSUE;
                end
            end
            PH_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    phase_next = PH_IDLE;
                end
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    // Datapath next values
    logic signed [31:0]    st1_a;
    logic signed [BW-1:0]  st1_b;
    logic [PW:0]           st4_full;
    logic [RW-1:0]         st4_rnd, st4_mag, st4_neg;
    logic signed [DW-1:0]  st4_term;
    logic signed [ACC_W-1:0] term_ext;

    always_comb begin
        // stage one operands
        st1_a = p1_mem_reg ? gain_q : p1_a_reg;
        if (p1_mem_reg) begin
            st1_b = BW'(signed'(axis_reg ? ref_q[63:32] : ref_q[31:0]));
        end else begin
            st1_b = BW'(p1_b_reg);
        end
        // round, clamp and sign the product
        st4_full = (PW + 1)'({p3_hi_reg, {HALF{1'b0}}}) + (PW + 1)'(p3_lo_reg)
                 + (PW + 1)'(ROUND_HALF);
        st4_rnd  = st4_full[PW:Q_FRAC];
        if (p3_neg_reg) begin
            st4_mag  = (st4_rnd > LIM_NEG) ? LIM_NEG : st4_rnd;
            st4_neg  = RW'(0) - st4_mag;
            st4_term = st4_neg[DW-1:0];
        end else begin
            st4_mag  = (st4_rnd > LIM_POS) ? LIM_POS : st4_rnd;
            st4_neg  = st4_mag;
            st4_term = st4_mag[DW-1:0];
        end
        term_ext = ACC_W'(p4_term_reg);
    end

    always_comb begin
        group_next    = group_reg;
        axis_next     = axis_reg;
        kcnt_next     = kcnt_reg;
        gidx_next     = gidx_reg;
        rptr_next     = rptr_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        p1_v_next     = 1'b0;
        p1_mem_next   = 1'b0;
        p1_first_next = 1'b0;
        p1_a_next     = '0;
        p1_b_next     = '0;
        acc_next      = acc_reg;
        u_next        = u_reg;
        n0_next       = n0_reg;
        n1_next       = n1_reg;
        n2_next       = n2_reg;
        ref0_next     = ref0_reg;
        sx0_next = sx0_reg; sx1_next = sx1_reg; sx2_next = sx2_reg; ex_next = ex_reg;
        sy0_next = sy0_reg; sy1_next = sy1_reg; sy2_next = sy2_reg; ey_next = ey_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_data_next   = m_data_reg;

        // capture the oldest reference as it leaves memory
        if (p1_v_reg && p1_first_reg) begin
            ref0_next = st1_b[31:0];
        end
        // accumulate finished products
        if (p4_v_reg) begin
            if (group_reg == GR_U || group_reg == GR_Z) begin
                acc_next = acc_reg - term_ext;
            end else begin
                acc_next = acc_reg + term_ext;
            end
        end

        case (phase_reg)
            PH_IDLE: begin
                if (s_acc && in_cmd == CMD_TICK) begin
                    if (count_reg != FULL_CNT) begin
                        count_next = count_reg + CW'(1);
                    end
                    group_next = GR_U;
                    axis_next  = 1'b0;
                    kcnt_next  = '0;
                    gidx_next  = '0;
                    rptr_next  = head_reg;
                    acc_next   = '0;
                end
            end
            PH_ISSUE: begin
                p1_v_next = 1'b1;
                kcnt_next = kcnt_reg + KW'(1);
                case (group_reg)
                    GR_U: begin
                        if (kcnt_reg >= U_MEM_K) begin
                            p1_mem_next   = 1'b1;
                            p1_first_next = (kcnt_reg == U_MEM_K);
                            gidx_next     = gidx_reg + AW'(1);
                            rptr_next     = (rptr_reg == LAST_IDX) ? '0 : rptr_reg + AW'(1);
                        end else if (kcnt_reg == KW'(0)) begin
                            p1_a_next = ki_reg; p1_b_next = cerr;
                        end else if (kcnt_reg == KW'(1)) begin
                            p1_a_next = kp_reg; p1_b_next = cs0;
                        end else if (kcnt_reg == KW'(2)) begin
                            p1_a_next = kv_reg; p1_b_next = cs1;
                        end else begin
                            p1_a_next = ka_reg; p1_b_next = cs2;
                        end
                    end
                    GR_N0: begin
                        if (kcnt_reg == KW'(0)) begin
                            p1_a_next = {1'b0, dt_reg}; p1_b_next = cs1;
                        end else if (kcnt_reg == KW'(1)) begin
                            p1_a_next = {1'b0, dt2_reg}; p1_b_next = cs2;
                        end else begin
                            p1_a_next = {1'b0, dt3_reg}; p1_b_next = u_reg;
                        end
                    end
                    GR_N1: begin
                        if (kcnt_reg == KW'(0)) begin
                            p1_a_next = {1'b0, dt_reg}; p1_b_next = cs2;
                        end else begin
                            p1_a_next = {1'b0, dt2_reg}; p1_b_next = u_reg;
                        end
                    end
                    GR_N2: begin
                        p1_a_next = {1'b0, dt_reg}; p1_b_next = u_reg;
                    end
                    default: begin
                        p1_a_next = {1'b0, hf_reg}; p1_b_next = n2_reg;
                    end
                endcase
            end
            PH_CLOSE: begin
                kcnt_next = '0;
                case (group_reg)
                    GR_U: begin
                        u_next     = sat_v;
                        group_next = GR_N0;
                        acc_next   = ACC_W'(cs0);
                    end
                    GR_N0: begin
                        n0_next    = sat_v;
                        group_next = GR_N1;
                        acc_next   = ACC_W'(cs1);
                    end
                    GR_N1: begin
                        n1_next    = sat_v;
                        group_next = GR_N2;
                        acc_next   = ACC_W'(cs2);
                    end
                    GR_N2: begin
                        n2_next    = sat_v;
                        group_next = GR_Z;
                        acc_next   = ACC_W'(n0_reg);
                    end
                    GR_Z: begin
                        group_next = GR_E;
                        acc_next   = ACC_W'(cerr) + ACC_W'(sat_v) - ACC_W'(ref0_reg);
                    end
                    default: begin
                        // commit the axis and move on
                        if (axis_reg) begin
                            sy0_next = n0_reg; sy1_next = n1_reg; sy2_next = n2_reg;
                            ey_next  = sat_v;
                            head_next = (head_reg == LAST_IDX) ? '0 : head_reg + AW'(1);
                        end else begin
                            sx0_next = n0_reg; sx1_next = n1_reg; sx2_next = n2_reg;
                            ex_next  = sat_v;
                            axis_next  = 1'b1;
                            group_next = GR_U;
                            gidx_next  = '0;
                            rptr_next  = head_reg;
                            acc_next   = '0;
                        end
                    end
                endcase
            end
            PH_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = {out32(sy2_reg), out32(sy1_reg), out32(sy0_reg),
                                     out32(sx2_reg), out32(sx1_reg), out32(sx0_reg)};
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            group_reg    <= GR_U;
            axis_reg     <= 1'b0;
            kcnt_reg     <= '0;
            gidx_reg     <= '0;
            rptr_reg     <= '0;
            head_reg     <= '0;
            count_reg    <= '0;
            p1_v_reg     <= 1'b0;
            p2_v_reg     <= 1'b0;
            p3_v_reg     <= 1'b0;
            p4_v_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            sx0_reg <= '0; sx1_reg <= '0; sx2_reg <= '0; ex_reg <= '0;
            sy0_reg <= '0; sy1_reg <= '0; sy2_reg <= '0; ey_reg <= '0;
        end else begin
            phase_reg    <= phase_next;
            group_reg    <= group_next;
            axis_reg     <= axis_next;
            kcnt_reg     <= kcnt_next;
            gidx_reg     <= gidx_next;
            rptr_reg     <= rptr_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            p1_v_reg     <= p1_v_next;
            p2_v_reg     <= p1_v_reg;
            p3_v_reg     <= p2_v_reg;
            p4_v_reg     <= p3_v_reg;
            m_tvalid_reg <= m_tvalid_next;
            sx0_reg <= sx0_next; sx1_reg <= sx1_next; sx2_reg <= sx2_next; ex_reg <= ex_next;
            sy0_reg <= sy0_next; sy1_reg <= sy1_next; sy2_reg <= sy2_next; ey_reg <= ey_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        p1_mem_reg   <= p1_mem_next;
        p1_first_reg <= p1_first_next;
        p1_a_reg     <= p1_a_next;
        p1_b_reg     <= p1_b_next;
        // magnitudes and sign
        p2_neg_reg   <= st1_a[31] ^ st1_b[BW-1];
        p2_ma_reg    <= st1_a[31] ? 32'(-st1_a) : 32'(st1_a);
        p2_mb_reg    <= st1_b[BW-1] ? BW'(-st1_b) : BW'(st1_b);
        // partial products
        p3_neg_reg   <= p2_neg_reg;
        p3_lo_reg    <= (32 + HALF)'(p2_ma_reg) * (32 + HALF)'(p2_mb_reg[HALF-1:0]);
        p3_hi_reg    <= (32 + HI_W)'(p2_ma_reg) * (32 + HI_W)'(p2_mb_reg[BW-1:HALF]);
        p4_term_reg  <= st4_term;
        acc_reg      <= acc_next;
        u_reg        <= u_next;
        n0_reg       <= n0_next;
        n1_reg       <= n1_next;
        n2_reg       <= n2_next;
        ref0_reg     <= ref0_next;
        m_data_reg   <= m_data_next;
    end

    assign s_tready = (phase_reg == PH_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("window count beyond capacity");

    a_close_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_CLOSE |-> pipe_empty)
        else $error("group closed with products in flight");

    a_out_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(phase_reg == PH_OUT))
        else $error("result raised outside output phase");

    a_head_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg != $past(head_reg) |->
            $past(phase_reg == PH_CLOSE && group_reg == GR_E && axis_reg))
        else $error("window head moved outside end of tick");

    a_idle_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_IDLE |-> !p4_v_reg && !p3_v_reg)
        else $error("pipeline busy while idle");
`endif

endmodule : zmp_preview_control_step_top
`default_nettype wire
